/* hw/rtl/mkslp_pkg.sv */
// mkslp_pkg: shared types, constants and register codes for the multi-key press detector
// used by the lane, merge, top level and checker files; no dependencies
package mkslp_pkg;

    localparam int KEY_COUNT_DEF = 5;
    localparam int LEVEL_BITS    = 5;
    localparam int COUNT_W       = 8;
    localparam int CODE_W        = 4;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'd255;
    localparam logic [COUNT_W-1:0] SHORT_MIN_RST      = 8'd8;
    localparam logic [COUNT_W-1:0] SHORT_MAX_RST      = 8'd40;
    localparam logic [COUNT_W-1:0] LONG_THRESHOLD_RST = 8'd80;
    localparam logic               ACTIVE_LEVEL_RST   = 1'b0;

    // register index codes (paddr[3:2])
    localparam logic [1:0] REG_ACTIVE_LEVEL   = 2'd0;
    localparam logic [1:0] REG_SHORT_MIN      = 2'd1;
    localparam logic [1:0] REG_SHORT_MAX      = 2'd2;
    localparam logic [1:0] REG_LONG_THRESHOLD = 2'd3;

    typedef struct packed {
        logic               active_level;
        logic [COUNT_W-1:0] short_min;
        logic [COUNT_W-1:0] short_max;
        logic [COUNT_W-1:0] long_threshold;
    } cfg_t;

    typedef struct packed {
        logic hit;
        logic long_press;
    } lane_stat_t;

endpackage

/* hw/rtl/mkslp_lane.sv */
// mkslp_lane: one key's hold counter and its short/long press test
// depends on mkslp_pkg
module mkslp_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  mkslp_pkg::cfg_t     cfg,
    input  logic                level,
    input  logic                upd,
    output mkslp_pkg::lane_stat_t stat
);
    import mkslp_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               pressed;

    assign pressed   = (level == cfg.active_level);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    always_comb begin
        if (pressed) begin
            count_next      = count_inc;
            stat.hit        = (count_inc > cfg.long_threshold);
            stat.long_press = 1'b1;
        end else begin
            count_next      = '0;
            stat.hit        = (count_reg > cfg.short_min) && (count_reg < cfg.short_max);
            stat.long_press = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (upd) begin
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/mkslp_merge.sv */
// mkslp_merge: picks the lowest key that reports, builds the event code
// and the mask of lanes that take their update on this tick; depends on mkslp_pkg
module mkslp_merge #(
    parameter int KEY_COUNT = mkslp_pkg::KEY_COUNT_DEF
) (
    input  logic                          tick,
    input  mkslp_pkg::lane_stat_t         stat [KEY_COUNT],
    output logic [KEY_COUNT-1:0]          upd_mask,
    output logic [mkslp_pkg::CODE_W-1:0]  event_code
);
    import mkslp_pkg::*;

    localparam int IW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CW = IW + 2;

    logic [KEY_COUNT-1:0] hit_vec;
    logic [KEY_COUNT-1:0] long_vec;
    logic [KEY_COUNT-1:0] lowbit;
    logic [IW-1:0]        idx;
    logic                 sel_long;
    logic [CW-1:0]        code_full;

    always_comb begin
        for (int i = 0; i < KEY_COUNT; i++) begin
            hit_vec[i]  = stat[i].hit & tick;
            long_vec[i] = stat[i].long_press;
        end
    end

    // isolate the first reporting key; lanes up to and including it are updated, or all lanes when none reports
    assign lowbit   = hit_vec & (~hit_vec + KEY_COUNT'(1));
    assign upd_mask = lowbit | (lowbit - KEY_COUNT'(1));
    assign sel_long = |(lowbit & long_vec);

    always_comb begin
        idx = '0;
        for (int i = 0; i < KEY_COUNT; i++) begin
            if (lowbit[i]) begin
                idx = idx | IW'(i);
            end
        end
    end

    // key k = idx+1: short 2k-1 = 2*idx+1, long 2k = 2*idx+2
    always_comb begin
        if (|hit_vec) begin
            code_full = CW'({idx, 1'b0}) + CW'(1) + CW'(sel_long);
        end else begin
            code_full = '0;
        end
    end

    assign event_code = CODE_W'(code_full);

endmodule

/* hw/rtl/multi_key_short_long_press_core.sv */
// multi_key_short_long_press_core: multi-key short/long press detector
// uses KEY_COUNT mkslp_lane instances and one mkslp_merge; depends on mkslp_pkg
//
// Usage:
//   s_ channel: one transfer per scan sample. s_tuser[0] is the scan tick,
//   s_tdata[4:0] holds the key levels (bit 0 is key 1). A transfer with the
//   tick low changes nothing and yields code 0.
//   m_ channel: one transfer per input transfer, m_tdata[3:0] is the event
//   code (0 none, 2k-1 short press of key k, 2k long press of key k).
//   APB port: four registers at 0x0 active_level, 0x4 short_min,
//   0x8 short_max, 0xC long_threshold; pready is always high.
// Timing:
//   the result is registered and valid in the cycle after the input transfer.
//   One item per cycle is sustained while m_tready stays high: all lanes
//   and the priority merge evaluate in the cycle of the transfer and the
//   hold counters update at that edge. When the receiver stalls, the single
//   output register holds its result and s_tready drops until it is taken.
// Reset: clears all hold counters and the output valid, and loads the
//   register defaults (active level 0, short window 8..40, long 80).
module multi_key_short_long_press_core #(
    parameter int KEY_COUNT = mkslp_pkg::KEY_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] key_levels
    input  logic [0:0]  s_tuser,   // [0] scan_tick
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] event_code
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mkslp_pkg::ADDR_W-1:0]   paddr,
    input  logic [mkslp_pkg::DATA_W-1:0]   pwdata,
    output logic [mkslp_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    import mkslp_pkg::*;

    cfg_t                 cfg_reg;
    logic                 in_xfer;
    logic                 cfg_wr;
    logic [1:0]           reg_idx;
    lane_stat_t           stat [KEY_COUNT];
    logic [KEY_COUNT-1:0] upd_mask;
    logic [CODE_W-1:0]    event_code;
    logic                 m_tvalid_reg;
    logic [CODE_W-1:0]    m_code_reg;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[3:2];
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level   <= ACTIVE_LEVEL_RST;
            cfg_reg.short_min      <= SHORT_MIN_RST;
            cfg_reg.short_max      <= SHORT_MAX_RST;
            cfg_reg.long_threshold <= LONG_THRESHOLD_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ACTIVE_LEVEL:   cfg_reg.active_level   <= pwdata[0];
                REG_SHORT_MIN:      cfg_reg.short_min      <= pwdata[COUNT_W-1:0];
                REG_SHORT_MAX:      cfg_reg.short_max      <= pwdata[COUNT_W-1:0];
                REG_LONG_THRESHOLD: cfg_reg.long_threshold <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACTIVE_LEVEL:   prdata = DATA_W'(cfg_reg.active_level);
            REG_SHORT_MIN:      prdata = DATA_W'(cfg_reg.short_min);
            REG_SHORT_MAX:      prdata = DATA_W'(cfg_reg.short_max);
            REG_LONG_THRESHOLD: prdata = DATA_W'(cfg_reg.long_threshold);
            default:            prdata = '0;
        endcase
    end

    for (genvar g = 0; g < KEY_COUNT; g++) begin : g_lane
        logic level;
        // keys past the sampled width read level 0
        if (g < LEVEL_BITS) begin : g_pin
            assign level = s_tdata[g];
        end else begin : g_nopin
            assign level = 1'b0;
        end

        mkslp_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg_reg),
            .level   (level),
            .upd     (in_xfer & s_tuser[0] & upd_mask[g]),
            .stat    (stat[g])
        );
    end

    mkslp_merge #(
        .KEY_COUNT (KEY_COUNT)
    ) u_merge (
        .tick       (s_tuser[0]),
        .stat       (stat),
        .upd_mask   (upd_mask),
        .event_code (event_code)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_code_reg <= event_code;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8-CODE_W){1'b0}}, m_code_reg};

endmodule

/* hw/rtl/mkslp_checker.sv */
// mkslp_checker: port-level assertions for the multi-key press detector,
// bound to multi_key_short_long_press_core; depends on mkslp_pkg
module mkslp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [0:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [7:0]                     m_tdata,
    input logic                           pready
);
    import mkslp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // with the output register empty the input side is open
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // every input transfer yields a result next cycle; idle input gives code 0
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> m_tvalid && m_tdata == 8'd0)
        else $error("idle sample gave an event");

    a_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("transfer gave no result");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:CODE_W] == '0 && pready)
        else $error("result padding not zero");

endmodule

bind multi_key_short_long_press_core mkslp_checker u_mkslp_checker (.*);

/* bench/tb.sv */
// tb: self-checking bench for multi_key_short_long_press_core, key hold / release scans
// needs mkslp_pkg and the core RTL; predicts every event code and compares transfer by transfer
`timescale 1ns / 100ps

module tb;
    import mkslp_pkg::*;

    localparam int PERIOD      = 4;
    localparam int NKEYS       = KEY_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NOT_TYPED   = -1;
    localparam int PHASE_TICKS = 40;

    typedef enum logic { ROW_SCAN, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        tick;
        logic [4:0]  levels;
        int          typed;
        logic [1:0]  reg_idx;
        logic [7:0]  value;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [4:0] key_levels, [7:5] zero
    logic [0:0]  s_tuser;   // [0] scan_tick
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [3:0] event_code
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor state
    cfg_t        press_cfg;
    logic [7:0]  hold_cnt [NKEYS];
    logic [3:0]  pending_codes [$];

    stim_row_t   stim_rows [$];
    int          errors;
    int          cycles;
    int          ticks_sent;
    bit          full_rate;
    int          stall_left;
    int          stall_roll;

    always #(PERIOD / 2) aclk = ~aclk;

    multi_key_short_long_press_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // one scan: keys visited from key 1, first event stops the walk
    function automatic logic [3:0] scan_keys(input logic tick, input logic [4:0] levels);
        logic [3:0] code;
        logic [7:0] cnt;
        bit         done;
        code = '0;
        done = 0;
        if (tick) begin
            for (int k = 0; k < NKEYS; k++) begin
                if (!done) begin
                    if (levels[k] == press_cfg.active_level) begin
                        if (hold_cnt[k] != COUNT_MAX) hold_cnt[k] = hold_cnt[k] + 8'd1;
                        if (hold_cnt[k] > press_cfg.long_threshold) begin
                            code = 4'(2 * k + 2);
                            done = 1;
                        end
                    end else begin
                        cnt = hold_cnt[k];
                        hold_cnt[k] = '0;
                        if (cnt > press_cfg.short_min && cnt < press_cfg.short_max) begin
                            code = 4'(2 * k + 1);
                            done = 1;
                        end
                    end
                end
            end
        end
        return code;
    endfunction

    function automatic logic [4:0] pins_for(input logic [4:0] pressed);
        return press_cfg.active_level ? pressed : ~pressed;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_rate || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // hold length aimed at the short window, the long threshold or their edges
    function automatic int pick_hold();
        int r;
        int lo;
        int hi;
        int lng;
        r   = $urandom_range(0, 99);
        lo  = int'(press_cfg.short_min);
        hi  = int'(press_cfg.short_max);
        lng = int'(press_cfg.long_threshold);
        if (r < 40) begin
            if (lo + 1 < hi) return $urandom_range(lo + 1, hi - 1);
            return $urandom_range(1, 10);
        end
        if (r < 70) begin
            if (lng >= 255) return $urandom_range(1, 20);
            return $urandom_range(lng + 1, (lng + 4 > 255) ? 255 : lng + 4);
        end
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: return (lo < 1) ? 1 : lo;
                1: return (hi < 1) ? 1 : hi;
                2: return (lng < 1) ? 1 : lng;
                default: return lng + 1;
            endcase
        end
        return $urandom_range(1, 12);
    endfunction

    task automatic send_item(input logic tick, input logic [4:0] levels, input int typed);
        int gap;
        logic [3:0] code;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, levels};
        s_tuser  <= tick;
        do @(posedge aclk); while (!s_tready);
        code = scan_keys(tick, levels);
        pending_codes.push_back((typed == NOT_TYPED) ? code : 4'(typed));
        if (tick) ticks_sent++;
    endtask

    // stop sending and let every expected result arrive
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        drain_results();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_ACTIVE_LEVEL:   press_cfg.active_level   = value[0];
            REG_SHORT_MIN:      press_cfg.short_min      = value;
            REG_SHORT_MAX:      press_cfg.short_max      = value;
            REG_LONG_THRESHOLD: press_cfg.long_threshold = value;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_scan(input logic tick, input logic [4:0] levels, input int typed);
        stim_row_t row;
        row = '{ROW_SCAN, tick, levels, typed, REG_ACTIVE_LEVEL, 8'd0};
        stim_rows.push_back(row);
    endtask

    task automatic add_write(input logic [1:0] idx, input logic [7:0] value);
        stim_row_t row;
        row = '{ROW_WRITE, 1'b0, 5'd0, NOT_TYPED, idx, value};
        stim_rows.push_back(row);
    endtask

    task automatic hold_keys(input logic [4:0] pressed, input int len);
        for (int i = 0; i < len; i++) send_item(1'b1, pins_for(pressed), NOT_TYPED);
        send_item(1'b1, pins_for(5'd0), NOT_TYPED);
    endtask

    // press a key set, hold with some bounce and idle transfers, then let go
    task automatic press_sequence();
        logic [4:0] mask;
        logic [4:0] pressed;
        logic [4:0] left;
        int len;
        mask = 5'($urandom_range(1, 31));
        len  = pick_hold();
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(1'b0, 5'($urandom_range(0, 31)), NOT_TYPED);
            pressed = mask;
            if ($urandom_range(0, 19) == 0) pressed[$urandom_range(0, 4)] ^= 1'b1;
            send_item(1'b1, pins_for(pressed), NOT_TYPED);
        end
        if ($urandom_range(0, 2) == 0) begin
            left = mask & 5'($urandom_range(0, 31));
            repeat ($urandom_range(1, 2)) send_item(1'b1, pins_for(left), NOT_TYPED);
        end
        send_item(1'b1, pins_for(5'd0), NOT_TYPED);
    endtask

    task automatic run_phase(input logic [7:0] act, input logic [7:0] smin,
                             input logic [7:0] smax, input logic [7:0] lng,
                             input bit saturate, input bit pause_mid);
        int stop_at;
        bit paused;
        write_reg(REG_ACTIVE_LEVEL, act);
        write_reg(REG_SHORT_MIN, smin);
        write_reg(REG_SHORT_MAX, smax);
        write_reg(REG_LONG_THRESHOLD, lng);
        paused = 0;
        if (saturate) hold_keys(5'($urandom_range(1, 31)), 258);
        stop_at = ticks_sent + PHASE_TICKS;
        while (ticks_sent < stop_at) begin
            full_rate = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 25) begin
                repeat ($urandom_range(1, 8))
                    send_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), NOT_TYPED);
            end else begin
                press_sequence();
            end
            if (pause_mid && !paused && ticks_sent > stop_at - PHASE_TICKS / 2) begin
                drain_results();
                paused = 1;
            end
        end
        full_rate = 0;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_codes.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transfer: event_code %0d", m_tdata[3:0]);
            end else begin
                if (m_tdata[3:0] !== pending_codes[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("event_code mismatch: expected %0d, got %0d",
                                 pending_codes[0], m_tdata[3:0]);
                end
                void'(pending_codes.pop_front());
            end
        end
    end

    // receiver stalls: mostly short, a few long
    always @(negedge aclk) begin
        stall_roll = $urandom_range(0, 99);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (full_rate || stall_roll < 75) begin
            m_tready <= 1'b1;
        end else if (stall_roll < 95) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(8, 30);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        errors     = 0;
        cycles     = 0;
        ticks_sent = 0;
        full_rate  = 0;
        stall_left = 0;
        press_cfg  = '{ACTIVE_LEVEL_RST, SHORT_MIN_RST, SHORT_MAX_RST, LONG_THRESHOLD_RST};
        foreach (hold_cnt[k]) hold_cnt[k] = '0;

        // directed rows; active low at reset, so a 0 bit is a held key
        add_scan(1'b0, 5'h00, 0);              // idle right after reset
        add_scan(1'b1, 5'h1F, 0);              // all released, counters empty
        add_scan(1'b0, 5'h1F, 0);
        add_write(REG_SHORT_MIN, 8'd0);
        add_write(REG_SHORT_MAX, 8'd3);
        add_write(REG_LONG_THRESHOLD, 8'd2);
        add_scan(1'b1, 5'h00, NOT_TYPED);
        add_scan(1'b1, 5'h00, NOT_TYPED);
        add_scan(1'b1, 5'h01, NOT_TYPED);      // key 1 short, scan stops there
        add_scan(1'b1, 5'h00, NOT_TYPED);      // key 2 long
        add_scan(1'b0, 5'h15, 0);              // idle leaves counters alone
        add_scan(1'b1, 5'h0F, NOT_TYPED);
        add_scan(1'b1, 5'h1D, NOT_TYPED);
        add_write(REG_ACTIVE_LEVEL, 8'd1);
        add_scan(1'b1, 5'h10, NOT_TYPED);
        add_scan(1'b1, 5'h10, NOT_TYPED);
        add_scan(1'b1, 5'h10, NOT_TYPED);      // key 5 long
        add_scan(1'b1, 5'h00, NOT_TYPED);
        add_scan(1'b1, 5'h10, NOT_TYPED);
        add_scan(1'b1, 5'h00, NOT_TYPED);      // key 5 short
        add_write(REG_LONG_THRESHOLD, 8'd0);
        add_scan(1'b1, 5'h01, NOT_TYPED);      // any hold is long at threshold 0
        add_write(REG_SHORT_MIN, 8'd255);
        add_write(REG_SHORT_MAX, 8'd0);
        add_scan(1'b1, 5'h00, 0);              // empty short window
        add_scan(1'b1, 5'h1F, NOT_TYPED);
        add_scan(1'b1, 5'h00, NOT_TYPED);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE)
                write_reg(stim_rows[i].reg_idx, stim_rows[i].value);
            else
                send_item(stim_rows[i].tick, stim_rows[i].levels, stim_rows[i].typed);
        end

        run_phase(8'd0, 8'd8,   8'd40,  8'd80,  1'b0, 1'b0);   // back to reset values
        run_phase(8'd1, 8'd2,   8'd10,  8'd20,  1'b0, 1'b0);
        run_phase(8'd0, 8'd0,   8'd255, 8'd255, 1'b1, 1'b0);   // long press impossible
        run_phase(8'd1, 8'd5,   8'd6,   8'd12,  1'b0, 1'b1);   // empty window, mid pause
        run_phase(8'd1, 8'd1,   8'd6,   8'd0,   1'b0, 1'b0);
        run_phase(8'd0, 8'd255, 8'd255, 8'd254, 1'b0, 1'b0);
        run_phase(8'd0, 8'd4,   8'd30,  8'd50,  1'b0, 1'b0);

        drain_results();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
